/* design/trial_division_prime_test_assert.svh */
// ----------------------------------------------------------------------------
// Trial division prime test: assertion macros
// Implication checks on the block's clock, held off while reset is active.
// ----------------------------------------------------------------------------
`ifndef TRIAL_DIVISION_PRIME_TEST_ASSERT_SVH
`define TRIAL_DIVISION_PRIME_TEST_ASSERT_SVH

// same-cycle implication
`define TDPT_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define TDPT_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* design/tdpt_pkg.sv */
// ----------------------------------------------------------------------------
// Trial division prime test: package
// Constants shared by the block and its checks.
// ----------------------------------------------------------------------------
package tdpt_pkg;

    localparam int unsigned FIRST_DIVISOR = 2;

endpackage

/* design/trial_division_prime_test.sv */
// Candidates below two are reported composite in the cycle after accept; others run
// one division per trial divisor on the shared bit-serial restoring divider.
// s_ready is high only when no item is in flight or awaiting m_ready.
// Worst case with VALUE_BITS = 31 is 46340 divisions per item.
// aresetn (synchronous, active low) clears the sequencer and the result valid.
// ----------------------------------------------------------------------------
// Trial division prime test
// Divides the candidate by 2, 3, 4, ... with one shared divider; stops when
// the divisor exceeds the quotient (prime) or a remainder is zero (composite).
// ----------------------------------------------------------------------------
`include "trial_division_prime_test_assert.svh"

module trial_division_prime_test #(
    parameter int VALUE_BITS = 31
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic [VALUE_BITS-1:0] s_candidate,
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic                  m_is_prime
);
    import tdpt_pkg::*;

    localparam int DW = (VALUE_BITS + 1) / 2 + 1;
    localparam int CW = $clog2(VALUE_BITS + 1);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIV,
        ST_CHECK,
        ST_RESULT
    } state_t;

    state_t                state_reg;
    logic [VALUE_BITS-1:0] n_reg;
    logic [VALUE_BITS-1:0] q_reg;
    logic [DW-1:0]         d_reg;
    logic [DW-1:0]         r_reg;
    logic [CW-1:0]         cnt_reg;
    logic                  m_valid_reg;
    logic                  m_is_prime_reg;

    logic [DW:0]           shifted;
    logic [DW:0]           diff;
    logic                  fits;
    logic                  d_gt_q;
    logic                  small_in;

    // one restoring division step
    always_comb begin
        shifted  = {r_reg, q_reg[VALUE_BITS-1]};
        fits     = (shifted >= {1'b0, d_reg});
        diff     = shifted - {1'b0, d_reg};
        d_gt_q   = (VALUE_BITS'(d_reg) > q_reg);
        small_in = (s_candidate < VALUE_BITS'(FIRST_DIVISOR));
    end

    assign s_ready    = (state_reg == ST_IDLE);
    assign m_valid    = m_valid_reg;
    assign m_is_prime = m_is_prime_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            case (state_reg)
                ST_IDLE: begin
                    if (s_valid) begin
                        n_reg   <= s_candidate;
                        q_reg   <= s_candidate;
                        r_reg   <= '0;
                        d_reg   <= DW'(FIRST_DIVISOR);
                        cnt_reg <= '0;
                        if (small_in) begin
                            m_is_prime_reg <= 1'b0;
                            m_valid_reg    <= 1'b1;
                            state_reg      <= ST_RESULT;
                        end else begin
                            state_reg <= ST_DIV;
                        end
                    end
                end
                ST_DIV: begin
                    q_reg   <= {q_reg[VALUE_BITS-2:0], fits};
                    r_reg   <= fits ? diff[DW-1:0] : shifted[DW-1:0];
                    cnt_reg <= cnt_reg + 1'b1;
                    if (cnt_reg == CW'(VALUE_BITS - 1)) begin
                        state_reg <= ST_CHECK;
                    end
                end
                ST_CHECK: begin
                    if (d_gt_q) begin
                        m_is_prime_reg <= 1'b1;
                        m_valid_reg    <= 1'b1;
                        state_reg      <= ST_RESULT;
                    end else if (r_reg == '0) begin
                        m_is_prime_reg <= 1'b0;
                        m_valid_reg    <= 1'b1;
                        state_reg      <= ST_RESULT;
                    end else begin
                        d_reg     <= d_reg + 1'b1;
                        q_reg     <= n_reg;
                        r_reg     <= '0;
                        cnt_reg   <= '0;
                        state_reg <= ST_DIV;
                    end
                end
                ST_RESULT: begin
                    if (m_ready) begin
                        m_valid_reg <= 1'b0;
                        state_reg   <= ST_IDLE;
                    end
                end
                default: begin
                    m_valid_reg <= 1'b0;
                    state_reg   <= ST_IDLE;
                end
            endcase
        end
    end

    `TDPT_ASSERT_IMP(a_ready_no_result, s_ready, !m_valid, "input ready while result pending")
    `TDPT_ASSERT_NXT(a_small_not_prime, s_valid && s_ready && small_in,
        m_valid && !m_is_prime, "candidate below two not reported composite")
    `TDPT_ASSERT_IMP(a_divisor_min, state_reg == ST_DIV,
        d_reg >= DW'(FIRST_DIVISOR), "trial divisor below first divisor")
    `TDPT_ASSERT_IMP(a_rem_below_div, state_reg == ST_DIV || state_reg == ST_CHECK,
        r_reg < d_reg, "partial remainder not below divisor")

endmodule
